[hdl/dynamic_quantum_barrier_top_defines.svh]
// Assertion macros for the dynamic quantum barrier.
`ifndef DYNAMIC_QUANTUM_BARRIER_TOP_DEFINES_SVH
`define DYNAMIC_QUANTUM_BARRIER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication under an active-low reset.
`define DQB_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication under an active-low reset.
`define DQB_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define DQB_ASSERT_IMPLY(label, clk, rst_n, a, b, msg)
`define DQB_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif

`endif

[hdl/dqb_pkg.sv]
// Types, codes and constants shared by the dynamic quantum barrier files.
package dqb_pkg;

    localparam int MAX_MEMBERS = 128;
    localparam logic [7:0] THRESHOLD_CAP = 8'((MAX_MEMBERS < 255) ? MAX_MEMBERS : 255);

    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_INTERVAL  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_MEMBERS = 2'd2;

    localparam logic [2:0] OP_ARRIVE   = 3'd0;
    localparam logic [2:0] OP_WITHDRAW = 3'd1;
    localparam logic [2:0] OP_JOIN     = 3'd2;
    localparam logic [2:0] OP_LEAVE    = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;
    localparam logic [2:0] OP_INIT     = 3'd5;

    localparam logic [2:0] STATUS_WAITING   = 3'd0;
    localparam logic [2:0] STATUS_RELEASED  = 3'd1;
    localparam logic [2:0] STATUS_WITHDRAWN = 3'd2;
    localparam logic [2:0] STATUS_STALE     = 3'd3;
    localparam logic [2:0] STATUS_UPDATED   = 3'd4;
    localparam logic [2:0] STATUS_UNDERFLOW = 3'd5;
    localparam logic [2:0] STATUS_CLEARED   = 3'd6;
    localparam logic [2:0] STATUS_ABANDONED = 3'd7;

    localparam logic [1:0] STOP_CONTINUE = 2'd0;
    localparam logic [1:0] STOP_ABANDON  = 2'd2;

    typedef struct packed {
        logic [31:0] quantum_length;
        logic [47:0] check_interval;
        logic [7:0]  initial_members;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic        machine_running;
        logic        check_verdict;
        logic [31:0] seen_generation;
    } item_t;

    typedef struct packed {
        logic [31:0] generation;
        logic [2:0]  status;
        logic [1:0]  stop_code;
        logic        check_done;
    } result_t;

    typedef struct packed {
        logic [7:0]  member_threshold;
        logic [7:0]  waiter_count;
        logic [31:0] barrier_generation;
        logic        last_stop;
        logic [63:0] cycle_total;
        logic [63:0] next_check_point;
    } state_t;

endpackage

[hdl/dqb_if.sv]
// Valid/ready channel interfaces for barrier operations and their results.
interface dqb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic        machine_running;
    logic        check_verdict;
    logic [31:0] seen_generation;

    modport source (output valid, operation, machine_running, check_verdict, seen_generation,
                    input ready);
    modport sink (input valid, operation, machine_running, check_verdict, seen_generation,
                  output ready);
endinterface

interface dqb_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] generation;
    logic [2:0]  status;
    logic [1:0]  stop_code;
    logic        check_done;

    modport source (output valid, generation, status, stop_code, check_done, input ready);
    modport sink (input valid, generation, status, stop_code, check_done, output ready);
endinterface

[hdl/dqb_core.sv]
// Next-state and result logic for one barrier operation.
module dqb_core
    import dqb_pkg::*;
(
    input  state_t  st,
    input  cfg_t    cfg,
    input  item_t   item,
    output state_t  st_next,
    output result_t res
);

    logic [63:0] cycle_sum;
    logic [63:0] check_advance;
    logic        check_hit;
    logic [7:0]  thr_dec;
    logic [31:0] gen_inc;
    logic        same_gen;
    logic        arrive_complete;
    logic        leave_release;
    logic [7:0]  init_threshold;
    logic [1:0]  release_stop;

    always_comb
    begin
        cycle_sum       = st.cycle_total + {32'd0, cfg.quantum_length};
        check_hit       = (st.next_check_point != 64'd0)
                          && (cycle_sum >= st.next_check_point);
        check_advance   = st.next_check_point + {16'd0, cfg.check_interval};
        thr_dec         = st.member_threshold - 8'd1;
        gen_inc         = st.barrier_generation + 32'd1;
        same_gen        = (item.seen_generation == st.barrier_generation);
        arrive_complete = (st.member_threshold != 8'd0) && (st.waiter_count == thr_dec);
        leave_release   = (st.waiter_count != 8'd0) && (st.waiter_count == thr_dec);
        init_threshold  = (cfg.initial_members > THRESHOLD_CAP) ? THRESHOLD_CAP
                                                                : cfg.initial_members;
        release_stop    = check_hit ? {1'b0, item.check_verdict} : STOP_CONTINUE;

        st_next        = st;
        res.generation = st.barrier_generation;
        res.status     = STATUS_UPDATED;
        res.stop_code  = STOP_CONTINUE;
        res.check_done = 1'b0;

        unique case (item.operation)
            OP_ARRIVE:
            begin
                if (!same_gen)
                begin
                    res.status    = STATUS_STALE;
                    res.stop_code = {1'b0, st.last_stop};
                end
                else if (arrive_complete)
                begin
                    st_next.cycle_total = cycle_sum;
                    if (!item.machine_running)
                    begin
                        // Halted machine: time still advances but nobody is released.
                        res.status    = STATUS_ABANDONED;
                        res.stop_code = STOP_ABANDON;
                    end
                    else
                    begin
                        if (check_hit)
                        begin
                            st_next.next_check_point = check_advance;
                        end
                        st_next.waiter_count       = 8'd0;
                        st_next.barrier_generation = gen_inc;
                        st_next.last_stop          = release_stop[0];
                        res.generation             = gen_inc;
                        res.status                 = STATUS_RELEASED;
                        res.stop_code              = release_stop;
                        res.check_done             = check_hit;
                    end
                end
                else
                begin
                    if (st.waiter_count != 8'hFF)
                    begin
                        st_next.waiter_count = st.waiter_count + 8'd1;
                    end
                    res.status = STATUS_WAITING;
                end
            end
            OP_WITHDRAW:
            begin
                if (!same_gen)
                begin
                    res.status     = STATUS_STALE;
                    res.stop_code  = {1'b0, st.last_stop};
                    res.generation = item.seen_generation + 32'd1;
                end
                else if (st.waiter_count == 8'd0)
                begin
                    res.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    st_next.waiter_count = st.waiter_count - 8'd1;
                    res.status           = STATUS_WITHDRAWN;
                    res.stop_code        = STOP_ABANDON;
                end
            end
            OP_JOIN:
            begin
                if (st.member_threshold < THRESHOLD_CAP)
                begin
                    st_next.member_threshold = st.member_threshold + 8'd1;
                end
            end
            OP_LEAVE:
            begin
                if (st.member_threshold == 8'd0)
                begin
                    res.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    st_next.member_threshold = thr_dec;
                    // The departure may complete the present waiters; the verdict is ignored.
                    if (leave_release)
                    begin
                        st_next.cycle_total = cycle_sum;
                        if (check_hit)
                        begin
                            st_next.next_check_point = check_advance;
                        end
                        st_next.waiter_count       = 8'd0;
                        st_next.barrier_generation = gen_inc;
                        res.generation             = gen_inc;
                        res.status                 = STATUS_RELEASED;
                        res.check_done             = check_hit;
                    end
                end
            end
            OP_CLEAR:
            begin
                st_next.barrier_generation = 32'd0;
                st_next.waiter_count       = 8'd0;
                res.generation             = 32'd0;
                res.status                 = STATUS_CLEARED;
            end
            OP_INIT:
            begin
                st_next.member_threshold   = init_threshold;
                st_next.waiter_count       = 8'd0;
                st_next.barrier_generation = 32'd0;
                st_next.last_stop          = 1'b0;
                st_next.cycle_total        = 64'd0;
                st_next.next_check_point   = {16'd0, cfg.check_interval};
                res.generation             = 32'd0;
            end
            default:
            begin
                // Unused operation codes leave the state alone.
            end
        endcase
    end

endmodule

[hdl/dynamic_quantum_barrier_top.sv]
// Top level of the dynamic quantum barrier: channel registers, state and configuration.
//
//  Channel | Direction | Transfer condition      | Payload
//  req     | sink      | req.valid && req.ready  | operation, machine_running, check_verdict,
//          |           |                         | seen_generation
//  rsp     | source    | rsp.valid && rsp.ready  | generation, status, stop_code, check_done
//  cfg     | write     | cfg_we                  | cfg_index, cfg_data
//
// One operation is taken per cycle unless a stalled result backs up the input register; its result
// is offered once the step logic behind the input register has been captured by the result register.
// Reset clears the barrier state and loads quantum_length 1, check_interval 0 and
// initial_members 0. A stalled result holds in the result register while one more operation
// waits in the input register; req.ready falls only when both are full.
`include "dynamic_quantum_barrier_top_defines.svh"

module dynamic_quantum_barrier_top
    import dqb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    dqb_req_if.sink                req,
    dqb_rsp_if.source              rsp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  step_state;
    result_t step_result;
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    result_t rsp_result_reg;
    logic    rsp_valid_reg;
    logic    rsp_valid_next;
    logic    out_free;
    logic    advance;
    logic    req_xfer;

    dqb_core u_core (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (s1_item_reg),
        .st_next (step_state),
        .res     (step_result)
    );

    always_comb
    begin
        out_free       = !rsp_valid_reg || rsp.ready;
        advance        = s1_valid_reg && out_free;
        req.ready      = !s1_valid_reg || out_free;
        req_xfer       = req.valid && req.ready;
        s1_valid_next  = req_xfer || (s1_valid_reg && !advance);
        rsp_valid_next = advance || (rsp_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg                <= 1'b0;
            rsp_valid_reg               <= 1'b0;
            state_reg                   <= '0;
            cfg_reg.quantum_length      <= 32'd1;
            cfg_reg.check_interval      <= 48'd0;
            cfg_reg.initial_members     <= 8'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                state_reg <= step_state;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUANTUM_LENGTH:  cfg_reg.quantum_length  <= cfg_data[31:0];
                    CFG_CHECK_INTERVAL:  cfg_reg.check_interval  <= cfg_data[47:0];
                    CFG_INITIAL_MEMBERS: cfg_reg.initial_members <= cfg_data[7:0];
                    default:
                    begin
                        // Writes beyond the register list are dropped.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_item_reg.operation       <= req.operation;
            s1_item_reg.machine_running <= req.machine_running;
            s1_item_reg.check_verdict   <= req.check_verdict;
            s1_item_reg.seen_generation <= req.seen_generation;
        end
        if (advance)
        begin
            rsp_result_reg <= step_result;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.generation = rsp_result_reg.generation;
    assign rsp.status     = rsp_result_reg.status;
    assign rsp.stop_code  = rsp_result_reg.stop_code;
    assign rsp.check_done = rsp_result_reg.check_done;

    `DQB_ASSERT_NEXT(a_threshold_capped, clk, rst_n, advance, state_reg.member_threshold <= THRESHOLD_CAP, "member threshold above cap")
    `DQB_ASSERT_NEXT(a_release_generation, clk, rst_n, advance && (step_result.status == STATUS_RELEASED), rsp_result_reg.generation == state_reg.barrier_generation, "released generation differs from state")
    `DQB_ASSERT_NEXT(a_check_advances, clk, rst_n, advance && step_result.check_done, state_reg.next_check_point == $past(state_reg.next_check_point) + {16'd0, $past(cfg_reg.check_interval)}, "check point did not advance by the interval")
    `DQB_ASSERT_IMPLY(a_no_advance_into_full, clk, rst_n, advance, !rsp_valid_reg || rsp.ready, "result register overwritten while stalled")

endmodule
